// ===== rtl/abgl_pkg.sv =====
// abgl_pkg: shared constants, types and register indexes for the bar-graph
// led matrix driver. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package abgl_pkg;

  // geometry of the matrix
  localparam int unsigned NUM_COLUMNS = 7;
  localparam int unsigned ROW_BITS    = 8;

  localparam int unsigned ColW   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int unsigned SampW  = 10;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned MultW  = $clog2(ROW_BITS + 1);
  localparam int unsigned ThrW   = SampW + MultW + 1;

  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 10;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  localparam logic [SampW-1:0]  OffsetReset = SampW'(20);
  localparam logic [ShiftW-1:0] ShiftReset  = ShiftW'(3);

  localparam logic [ROW_BITS-1:0] TopBit = ROW_BITS'(1) << (ROW_BITS - 1);
  localparam logic [ROW_BITS-1:0] LowBit = ROW_BITS'(1);

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_THRESHOLD_OFFSET = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_VOLUME_SHIFT     = 1'b1;

  // input kinds carried on tuser
  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  typedef enum logic [3:0] {
    PH_DATA     = 4'b0001,
    PH_CLK_HIGH = 4'b0010,
    PH_CLK_LOW  = 4'b0100,
    PH_CLEAR    = 4'b1000
  } scan_phase_e;

  typedef enum logic [7:0] {
    SQ_INIT          = 8'b0000_0001,
    SQ_STROBE_LOW_A  = 8'b0000_0010,
    SQ_STROBE_HIGH_A = 8'b0000_0100,
    SQ_RESET_LOW     = 8'b0000_1000,
    SQ_STROBE_LOW    = 8'b0001_0000,
    SQ_CONVERT       = 8'b0010_0000,
    SQ_WAIT          = 8'b0100_0000,
    SQ_NEXT_BAND     = 8'b1000_0000
  } seq_phase_e;

  typedef struct packed {
    logic reset;
    logic strobe;
    logic latch;
    logic clk;
    logic mux;
    logic led;
  } pins_t;

endpackage

`default_nettype wire

// ===== rtl/audio_bar_graph_led_matrix_driver.sv =====
// Bar-graph led matrix driver: scan sequencer, band-filter sequencer and
// level quantizer in one module. Depends on abgl_pkg.
//
// Usage:
//   s_axis: one transfer per event. tuser is the kind (0 = timer tick,
//   1 = conversion finished); tdata carries level and volume samples,
//   used only on a conversion transfer.
//   m_axis: one result transfer per input transfer, holding the pin levels
//   after the event plus the clear and convert-start pulse flags.
//   cfg: plain write port, index 0 = threshold offset, 1 = volume shift;
//   write only while no transfer is in flight.
// Timing: the result is registered and appears in the cycle after its input transfer.
// Throughput: one transfer per cycle while no result is held back; the state update and the
// eight threshold compares settle combinationally ahead of the result register.
// Reset: scan restarts at the data phase with marker 0x01, the sequencer at
// its initial strobe/reset phase, all bar masks and pins cleared,
// registers at offset 20 and shift 3.
// Stall: with a result waiting and m_axis_tready_i low, s_axis_tready_o
// drops; the result register holds until taken.
`timescale 1ns / 1ps
`default_nettype none

module audio_bar_graph_led_matrix_driver
  import abgl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [9:0] level_sample, [19:10] volume_sample, [23:20] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] action
  input  wire logic                s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [0] led_data [1] mux_data [2] shift_clock [3] latch_level
  // [4] clear_pulse [5] eq_strobe [6] eq_reset [7] convert_start
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [SampW-1:0]    offset_q;
  logic [ShiftW-1:0]   shift_q;

  scan_phase_e         scan_q, scan_d;
  logic [ROW_BITS-1:0] marker_q, marker_d;
  logic [ColW-1:0]     scan_col_q, scan_col_d;
  logic [ROW_BITS-1:0] bar_q [NUM_COLUMNS];
  seq_phase_e          seq_q, seq_d;
  logic [ColW-1:0]     band_q, band_d;
  logic                done_q, done_d;
  logic                parity_q, parity_d;
  pins_t               pins_q, pins_d;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic                in_fire;
  logic                is_conv;
  logic [SampW-1:0]    level;
  logic [SampW-1:0]    volume;
  logic [SampW-1:0]    step;
  logic [ROW_BITS-1:0] thermo;
  logic [ROW_BITS-1:0] col_sel;
  logic [ROW_BITS-1:0] shifted;
  logic                cleared;
  logic                start;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_conv         = (s_axis_tuser_i == ACT_CONVERT);
  assign level           = s_axis_tdata_i[SampW-1:0];
  assign volume          = s_axis_tdata_i[2*SampW-1:SampW];

  // shifts of ten or more give a zero step on their own
  assign step = volume >> shift_q;

  // thresholds rise with n, so the exceeded set is already a thermometer
  always_comb begin
    for (int n = 0; n < ROW_BITS; n++) begin
      thermo[n] = ThrW'(level) >
                  (ThrW'(n + 1) * ThrW'(step) + ThrW'(offset_q));
    end
  end

  assign col_sel = ROW_BITS'(1) << scan_col_q;
  assign shifted = marker_q >> 1;

  always_comb begin
    scan_d     = scan_q;
    marker_d   = marker_q;
    scan_col_d = scan_col_q;
    seq_d      = seq_q;
    band_d     = band_q;
    done_d     = done_q;
    parity_d   = parity_q;
    pins_d     = pins_q;
    cleared    = 1'b0;
    start      = 1'b0;

    if (in_fire) begin
      if (is_conv) begin
        done_d = 1'b1;
      end else begin
        unique case (scan_q)
          PH_DATA: begin
            pins_d.led = |(bar_q[scan_col_q] & marker_q);
            pins_d.mux = |(col_sel & marker_q);
            marker_d   = shifted;
            if (shifted == '0) begin
              marker_d   = TopBit;
              scan_col_d = (scan_col_q == ColW'(NUM_COLUMNS - 1)) ?
                           '0 : scan_col_q + ColW'(1);
            end
            scan_d = PH_CLK_HIGH;
          end
          PH_CLK_HIGH: begin
            pins_d.clk = 1'b1;
            if (marker_q == TopBit) begin
              pins_d.latch = 1'b1;
            end
            scan_d = PH_CLK_LOW;
          end
          PH_CLK_LOW: begin
            pins_d.clk = 1'b0;
            if (marker_q == TopBit) begin
              pins_d.latch = 1'b0;
              scan_d       = PH_CLEAR;
            end else begin
              scan_d = PH_DATA;
            end
          end
          default: begin
            cleared = 1'b1;
            scan_d  = PH_DATA;
          end
        endcase

        parity_d = !parity_q;
        if (parity_q) begin
          unique case (seq_q)
            SQ_INIT: begin
              pins_d.reset  = 1'b1;
              pins_d.strobe = 1'b1;
              seq_d         = SQ_STROBE_LOW_A;
            end
            SQ_STROBE_LOW_A: begin
              pins_d.strobe = 1'b0;
              seq_d         = SQ_STROBE_HIGH_A;
            end
            SQ_STROBE_HIGH_A: begin
              pins_d.strobe = 1'b1;
              seq_d         = SQ_RESET_LOW;
            end
            SQ_RESET_LOW: begin
              pins_d.reset = 1'b0;
              seq_d        = SQ_STROBE_LOW;
            end
            SQ_STROBE_LOW: begin
              pins_d.strobe = 1'b0;
              seq_d         = SQ_CONVERT;
            end
            SQ_CONVERT: begin
              start = 1'b1;
              seq_d = SQ_WAIT;
            end
            SQ_WAIT: begin
              if (done_q) begin
                done_d = 1'b0;
                seq_d  = SQ_NEXT_BAND;
              end
            end
            default: begin
              pins_d.strobe = 1'b1;
              band_d        = (band_q == ColW'(NUM_COLUMNS - 1)) ?
                              '0 : band_q + ColW'(1);
              seq_d         = SQ_STROBE_LOW;
            end
          endcase
        end
      end
    end
  end

  assign out_data_d = {start, pins_d.reset, pins_d.strobe, cleared,
                       pins_d.latch, pins_d.clk, pins_d.mux, pins_d.led};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
      shift_q  <= ShiftReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_THRESHOLD_OFFSET: offset_q <= cfg_data_i[SampW-1:0];
        CFG_VOLUME_SHIFT:     shift_q  <= cfg_data_i[ShiftW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= PH_DATA;
      marker_q   <= LowBit;
      scan_col_q <= '0;
      seq_q      <= SQ_INIT;
      band_q     <= '0;
      done_q     <= 1'b0;
      parity_q   <= 1'b0;
      pins_q     <= '0;
    end else begin
      scan_q     <= scan_d;
      marker_q   <= marker_d;
      scan_col_q <= scan_col_d;
      seq_q      <= seq_d;
      band_q     <= band_d;
      done_q     <= done_d;
      parity_q   <= parity_d;
      pins_q     <= pins_d;
    end
  end

  // mask store for the band being converted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        bar_q[c] <= '0;
      end
    end else if (in_fire && is_conv) begin
      bar_q[band_q] <= thermo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // clear pulse only follows the clock-low phase that dropped clock and latch
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[4]) |-> (!out_data_q[2] && !out_data_q[3]))
    else $error("clear pulse with shift clock or latch high");

  // conversion is only requested with strobe and reset both low
  a_start_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[7]) |-> (!out_data_q[5] && !out_data_q[6]))
    else $error("convert start with strobe or reset high");

  a_latch_clk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pins_q.latch |-> pins_q.clk)
    else $error("latch enabled while shift clock low");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(in_fire && is_conv))
    else $error("conversion flag set without a conversion transfer");

endmodule

`default_nettype wire

// ===== dv/tb_audio_bar_graph_led_matrix_driver.sv =====
// Self-checking testbench for the bar-graph led matrix driver: a directed table, then random
// tick and conversion streams under several threshold settings, checked against a pin predictor.
// Depends on abgl_pkg and the audio_bar_graph_led_matrix_driver rtl.
`timescale 1ns / 1ps

module tb_audio_bar_graph_led_matrix_driver;
  import abgl_pkg::*;

  localparam int unsigned MaxGap       = 18;
  localparam int unsigned LongHold     = 60;
  localparam int unsigned ItemsPerPass = 56;
  localparam int unsigned NumPasses    = 8;
  localparam int unsigned MaxReports   = 10;

  typedef struct {
    logic             act;
    logic [SampW-1:0] lvl;
    logic [SampW-1:0] vol;
    bit               typed;
    logic [7:0]       result;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = ACT_TICK;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = CFG_THRESHOLD_OFFSET;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor state
  logic [SampW-1:0]    offset_q;
  logic [ShiftW-1:0]   shift_q;
  scan_phase_e         scan_ph;
  logic [ROW_BITS-1:0] bit_mark;
  logic [ColW-1:0]     scan_col;
  logic [ROW_BITS-1:0] bar_mask [NUM_COLUMNS];
  seq_phase_e          seq_ph;
  logic [ColW-1:0]     band_col;
  logic                conv_pend;
  logic                tick_odd;
  pins_t               pins;

  logic [7:0] pins_expected [$];
  stim_row_t  stim_rows [$];

  string field_name [8] = '{"led_data", "mux_data", "shift_clock", "latch_level",
                            "clear_pulse", "eq_strobe", "eq_reset", "convert_start"};

  int  fail_cnt = 0;
  int  items_sent = 0;
  int  convs_sent = 0;
  int  results_seen = 0;
  int  clears_seen = 0;
  int  starts_seen = 0;
  int  cfg_writes = 0;
  bit  quiet_mode = 1'b0;
  bit  hold_req = 1'b0;

  audio_bar_graph_led_matrix_driver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    // [9:0] level_sample, [19:10] volume_sample, [23:20] zero
    .s_axis_tdata_i  (s_axis_tdata_i),
    // [0] action
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    // [0] led_data [1] mux_data [2] shift_clock [3] latch_level
    // [4] clear_pulse [5] eq_strobe [6] eq_reset [7] convert_start
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    if (quiet_mode || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, MaxGap);
  endfunction

  function automatic void reset_pin_model();
    offset_q  = OffsetReset;
    shift_q   = ShiftReset;
    scan_ph   = PH_DATA;
    bit_mark  = LowBit;
    scan_col  = '0;
    foreach (bar_mask[i]) bar_mask[i] = '0;
    seq_ph    = SQ_INIT;
    band_col  = '0;
    conv_pend = 1'b0;
    tick_odd  = 1'b0;
    pins      = '0;
  endfunction

  // advances the driver model by one event and returns the packed result
  function automatic logic [7:0] advance_pin_model(input logic act, input logic [SampW-1:0] lvl,
                                                   input logic [SampW-1:0] vol);
    logic                cleared;
    logic                start;
    logic [ROW_BITS-1:0] col_sel;
    int                  step;
    int                  k;
    cleared = 1'b0;
    start   = 1'b0;
    if (act == ACT_TICK) begin
      case (scan_ph)
        PH_DATA: begin
          col_sel  = ROW_BITS'(1) << scan_col;
          pins.led = |(bar_mask[scan_col] & bit_mark);
          pins.mux = |(col_sel & bit_mark);
          bit_mark = bit_mark >> 1;
          if (bit_mark == '0) begin
            bit_mark = TopBit;
            scan_col = (scan_col >= ColW'(NUM_COLUMNS - 1)) ? '0 : scan_col + 1'b1;
          end
          scan_ph = PH_CLK_HIGH;
        end
        PH_CLK_HIGH: begin
          pins.clk = 1'b1;
          if (bit_mark == TopBit) pins.latch = 1'b1;
          scan_ph = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          pins.clk = 1'b0;
          if (bit_mark == TopBit) begin
            pins.latch = 1'b0;
            scan_ph    = PH_CLEAR;
          end else begin
            scan_ph = PH_DATA;
          end
        end
        default: begin
          cleared = 1'b1;
          scan_ph = PH_DATA;
        end
      endcase
      // the band sequencer runs at half the tick rate
      if (tick_odd) begin
        tick_odd = 1'b0;
        case (seq_ph)
          SQ_INIT: begin
            pins.reset  = 1'b1;
            pins.strobe = 1'b1;
            seq_ph      = SQ_STROBE_LOW_A;
          end
          SQ_STROBE_LOW_A: begin
            pins.strobe = 1'b0;
            seq_ph      = SQ_STROBE_HIGH_A;
          end
          SQ_STROBE_HIGH_A: begin
            pins.strobe = 1'b1;
            seq_ph      = SQ_RESET_LOW;
          end
          SQ_RESET_LOW: begin
            pins.reset = 1'b0;
            seq_ph     = SQ_STROBE_LOW;
          end
          SQ_STROBE_LOW: begin
            pins.strobe = 1'b0;
            seq_ph      = SQ_CONVERT;
          end
          SQ_CONVERT: begin
            start  = 1'b1;
            seq_ph = SQ_WAIT;
          end
          SQ_WAIT: begin
            if (conv_pend) begin
              conv_pend = 1'b0;
              seq_ph    = SQ_NEXT_BAND;
            end
          end
          default: begin
            pins.strobe = 1'b1;
            band_col    = (band_col >= ColW'(NUM_COLUMNS - 1)) ? '0 : band_col + 1'b1;
            seq_ph      = SQ_STROBE_LOW;
          end
        endcase
      end else begin
        tick_odd = 1'b1;
      end
    end else begin
      step = int'(vol >> shift_q);
      k    = 0;
      for (int n = 1; n <= ROW_BITS; n++) begin
        if (int'(lvl) > n * step + int'(offset_q)) k = n;
      end
      bar_mask[band_col] = ROW_BITS'((1 << k) - 1);
      conv_pend = 1'b1;
    end
    return {start, pins.reset, pins.strobe, cleared, pins.latch, pins.clk, pins.mux, pins.led};
  endfunction

  // leaves tvalid high at the falling edge after the transfer
  task automatic send_event(input logic act, input logic [SampW-1:0] lvl,
                            input logic [SampW-1:0] vol, input bit typed,
                            input logic [7:0] typed_res);
    int         gap;
    logic [7:0] predicted;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser_i  = act;
    s_axis_tdata_i  = InDataW'({vol, lvl});
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = advance_pin_model(act, lvl, vol);
    pins_expected.push_back(typed ? typed_res : predicted);
    items_sent++;
    if (act == ACT_CONVERT) convs_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i = 1'b0;
    while (pins_expected.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_addr_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_THRESHOLD_OFFSET) offset_q = val[SampW-1:0];
    else shift_q = val[ShiftW-1:0];
    cfg_writes++;
  endtask

  task automatic send_random_event();
    logic             act;
    logic [SampW-1:0] lvl;
    logic [SampW-1:0] vol;
    int               step;
    int               near;
    vol = SampW'($urandom);
    lvl = SampW'($urandom);
    // answer a pending conversion most of the time, otherwise mostly ticks
    if (seq_ph == SQ_WAIT && !conv_pend) act = ($urandom_range(0, 9) < 6) ? ACT_CONVERT : ACT_TICK;
    else act = ($urandom_range(0, 15) == 0) ? ACT_CONVERT : ACT_TICK;
    if (act == ACT_CONVERT) begin
      case ($urandom_range(0, 3))
        0: vol = SampW'($urandom_range(0, 15));
        1: lvl = (vol[0]) ? '1 : '0;
        default: begin
          // land on or next to one of the bar thresholds
          step = int'(vol >> shift_q);
          near = int'(offset_q) + $urandom_range(1, ROW_BITS) * step + $urandom_range(0, 2) - 1;
          if (near < 0) near = 0;
          if (near > 1023) near = 1023;
          lvl = SampW'(near);
        end
      endcase
    end
    send_event(act, lvl, vol, 1'b0, '0);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int         stall;
    logic [7:0] want;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LongHold;
      end
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      results_seen++;
      if (m_axis_tdata_o[4] === 1'b1) clears_seen++;
      if (m_axis_tdata_o[7] === 1'b1) starts_seen++;
      if (pins_expected.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports) $display("unexpected result transfer: %b", m_axis_tdata_o);
      end else begin
        want = pins_expected.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (m_axis_tdata_o[i] !== want[i]) begin
            fail_cnt++;
            if (fail_cnt <= MaxReports) begin
              $display("result %0d %s: expected %b got %b", results_seen, field_name[i],
                       want[i], m_axis_tdata_o[i]);
            end
          end
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    logic [SampW-1:0]  pass_offset;
    logic [ShiftW-1:0] pass_shift;
    reset_pin_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // conversion before any tick carries the reset pin levels
    stim_rows.push_back('{ACT_CONVERT, 10'd0, 10'd0, 1'b1, 8'h00});
    // first column shifts a single bit: mux high, marker wraps to the top bit
    stim_rows.push_back('{ACT_TICK, 10'd0, 10'd0, 1'b1, 8'h02});
    // clock high with latch, sequencer raises strobe and reset
    stim_rows.push_back('{ACT_TICK, 10'd0, 10'd0, 1'b1, 8'h6e});
    stim_rows.push_back('{ACT_CONVERT, 10'd1023, 10'd0, 1'b1, 8'h6e});
    stim_rows.push_back('{ACT_CONVERT, 10'd1023, 10'd1023, 1'b0, 8'h00});
    stim_rows.push_back('{ACT_CONVERT, 10'd21, 10'd0, 1'b0, 8'h00});
    stim_rows.push_back('{ACT_CONVERT, 10'd20, 10'd0, 1'b0, 8'h00});
    stim_rows.push_back('{ACT_CONVERT, 10'd0, 10'd1023, 1'b0, 8'h00});
    repeat (17) stim_rows.push_back('{ACT_TICK, 10'd1023, 10'd1023, 1'b0, 8'h00});
    foreach (stim_rows[i]) begin
      send_event(stim_rows[i].act, stim_rows[i].lvl, stim_rows[i].vol, stim_rows[i].typed,
                 stim_rows[i].result);
    end

    for (int pass = 0; pass < NumPasses; pass++) begin
      if (pass > 0) begin
        drain_results();
        case (pass)
          1: begin pass_offset = '0;   pass_shift = '0; end
          2: begin pass_offset = '1;   pass_shift = 4'd9; end
          3: begin pass_offset = '0;   pass_shift = '1; end
          4: begin
            pass_offset = SampW'($urandom_range(0, 200));
            pass_shift  = ShiftW'($urandom_range(0, 9));
          end
          5: begin pass_offset = 10'd500; pass_shift = 4'd12; end
          6: begin
            pass_offset = SampW'($urandom);
            pass_shift  = ShiftW'($urandom);
          end
          default: begin pass_offset = OffsetReset; pass_shift = ShiftReset; end
        endcase
        write_cfg(CFG_THRESHOLD_OFFSET, CfgDataW'(pass_offset));
        write_cfg(CFG_VOLUME_SHIFT, CfgDataW'(pass_shift));
      end
      quiet_mode = (pass == 3);
      for (int i = 0; i < ItemsPerPass; i++) begin
        if ((pass == 1 || pass == 4) && i == 10) hold_req = 1'b1;
        // sender holds back until the result stream is empty
        if (pass == 2 && i == ItemsPerPass / 2) drain_results();
        send_random_event();
      end
    end

    drain_results();
    repeat (5) @(negedge clk_i);
    $display("sent %0d events (%0d conversions) over %0d register writes", items_sent,
             convs_sent, cfg_writes);
    $display("checked %0d results, %0d clear pulses, %0d conversion starts", results_seen,
             clears_seen, starts_seen);
    if (fail_cnt == 0 && pins_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches or stray results", fail_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pins_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/abgl_pkg.sv
rtl/audio_bar_graph_led_matrix_driver.sv
dv/tb_audio_bar_graph_led_matrix_driver.sv
